// ===== rtl/core/gpn_pkg.sv =====
// Shared types and constants for the grid point normal estimation block.
package gpn_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int PW     = 24;
    localparam int CFGW   = 11;
    localparam int CFG_IW = 1;
    localparam int NRMW   = 16;
    localparam int POSW   = 10;

    localparam int DIFW   = 25;
    localparam int OPW    = 31;
    localparam int PRODW  = 2 * OPW;
    localparam int NW     = 52;
    localparam int QW     = 62;
    localparam int LW     = 31;
    localparam int REMW   = 46;
    localparam int QUOW   = 15;
    localparam int STEPW  = 6;

    localparam logic [CFG_IW-1:0] REG_NUM_COLS = 1'b0;
    localparam logic [CFG_IW-1:0] REG_NUM_ROWS = 1'b1;

    localparam logic [QW-1:0] SQRT_BIT0 = QW'(1) << (QW - 2);

    localparam logic [STEPW-1:0] READ_LAST = STEPW'(4);
    localparam logic [STEPW-1:0] MUL_LAST  = STEPW'(12);
    localparam logic [STEPW-1:0] SQ_LAST   = STEPW'(3);
    localparam logic [STEPW-1:0] SQRT_LAST = STEPW'(31);
    localparam logic [STEPW-1:0] DIV_LAST  = STEPW'(47);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_CHECK,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             accept;
        logic             rd_en;
        logic             mul_en;
        logic             chk_en;
        logic             norm_en;
        logic             sq_en;
        logic             sqrt_en;
        logic             div_en;
        logic             load_out;
        logic [STEPW-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic n_zero;
        logic norm_ok;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/gpn_point_if.sv =====
// Input channel: one grid point per word.
interface gpn_point_if import gpn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] point_x;
    logic signed [PW-1:0] point_y;
    logic signed [PW-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// ===== rtl/core/gpn_normal_if.sv =====
// Output channel: one unit normal per word.
interface gpn_normal_if import gpn_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [NRMW-1:0] normal_x;
    logic signed [NRMW-1:0] normal_y;
    logic signed [NRMW-1:0] normal_z;
    logic [POSW-1:0]        center_row;
    logic [POSW-1:0]        center_col;
    logic                   interior;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output center_row, output center_col, output interior, input ready);
    modport sink (input valid, input normal_x, input normal_y, input normal_z,
                  input center_row, input center_col, input interior, output ready);
endinterface

// ===== rtl/core/gpn_cfg_if.sv =====
// Configuration write channel.
interface gpn_cfg_if import gpn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFGW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/gpn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module gpn_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 3072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/gpn_ctrl.sv =====
// Sequencer for the normal estimation datapath.
module gpn_ctrl import gpn_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [STEPW-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    if (!status.emit)
                        state_next = ST_IDLE;
                    else if (!status.interior)
                        state_next = ST_FIN;
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (step_reg == READ_LAST)
                begin
                    state_next = ST_MUL;
                    step_next  = '0;
                end
            end
            ST_MUL:
            begin
                if (step_reg == MUL_LAST)
                begin
                    state_next = ST_CHECK;
                    step_next  = '0;
                end
            end
            ST_CHECK:
            begin
                step_next  = '0;
                state_next = status.n_zero ? ST_FIN : ST_NORM;
            end
            ST_NORM:
            begin
                step_next = '0;
                if (status.norm_ok)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (step_reg == SQ_LAST)
                begin
                    state_next = ST_SQRT;
                    step_next  = '0;
                end
            end
            ST_SQRT:
            begin
                if (step_reg == SQRT_LAST)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                    step_next  = '0;
                end
            end
            ST_FIN:
            begin
                step_next = '0;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.step     = step_reg;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_READ:  cmd.rd_en    = 1'b1;
            ST_MUL:   cmd.mul_en   = 1'b1;
            ST_CHECK: cmd.chk_en   = 1'b1;
            ST_NORM:  cmd.norm_en  = 1'b1;
            ST_SQ:    cmd.sq_en    = 1'b1;
            ST_SQRT:  cmd.sqrt_en  = 1'b1;
            ST_DIV:   cmd.div_en   = 1'b1;
            ST_FIN:   cmd.load_out = status.out_free;
            default:  cmd.step     = step_reg;
        endcase
    end

endmodule

// ===== rtl/core/gpn_datapath.sv =====
// Row stores, grid position, cross products, normalization, sqrt and divide.
module gpn_datapath import gpn_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic signed [PW-1:0]   point_x,
    input  logic signed [PW-1:0]   point_y,
    input  logic signed [PW-1:0]   point_z,
    input  logic                   cfg_we,
    input  logic [CFG_IW-1:0]      cfg_index,
    input  logic [CFGW-1:0]        cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [NRMW-1:0] normal_x,
    output logic signed [NRMW-1:0] normal_y,
    output logic signed [NRMW-1:0] normal_z,
    output logic [POSW-1:0]        center_row,
    output logic [POSW-1:0]        center_col,
    output logic                   interior
);

    localparam int CW       = $clog2(MAX_COLS);
    localparam int RW       = $clog2(MAX_ROWS);
    localparam int CLW      = $clog2(MAX_COLS + 1);
    localparam int RLW      = $clog2(MAX_ROWS + 1);
    localparam int DEPTH    = 3 * MAX_COLS;
    localparam int AW       = $clog2(DEPTH);
    localparam int COLS_RST = (MAX_COLS < 100) ? MAX_COLS : 100;
    localparam int ROWS_RST = (MAX_ROWS < 100) ? MAX_ROWS : 100;

    function automatic logic [31:0] clamp(input logic [CFGW-1:0] v, input int hi);
        logic [31:0] w;
        w = 32'(v);
        if (w < 32'd3)
            clamp = 32'd3;
        else if (w > 32'(hi))
            clamp = 32'(hi);
        else
            clamp = w;
    endfunction

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        case (i)
            2'd0:    nxt3 = 2'd1;
            2'd1:    nxt3 = 2'd2;
            default: nxt3 = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] idx3(input logic [1:0] i);
        idx3 = (i == 2'd3) ? 2'd0 : i;
    endfunction

    function automatic logic [AW-1:0] base(input logic [1:0] s);
        case (s)
            2'd0:    base = '0;
            2'd1:    base = AW'(MAX_COLS);
            default: base = AW'(2 * MAX_COLS);
        endcase
    endfunction

    // grid position and configuration
    logic [CLW-1:0] cols_reg;
    logic [RLW-1:0] rows_reg;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [1:0]     slot_reg, slot_next;
    logic           col_wrap, row_wrap, interior_now;

    assign col_wrap = (32'(col_reg) + 32'd1) >= 32'(cols_reg);
    assign row_wrap = (32'(row_reg) + 32'd1) >= 32'(rows_reg);
    assign interior_now = !(row_reg == RW'(1) || col_reg == '0 || col_wrap);

    always_comb
    begin
        col_next  = col_reg + 1'b1;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (col_wrap)
        begin
            col_next = '0;
            if (row_wrap)
            begin
                row_next  = '0;
                slot_next = 2'd0;
            end
            else
            begin
                row_next  = row_reg + 1'b1;
                slot_next = nxt3(slot_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CLW'(COLS_RST);
            rows_reg <= RLW'(ROWS_RST);
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_NUM_COLS)
                cols_reg <= CLW'(clamp(cfg_data, MAX_COLS));
            else
                rows_reg <= RLW'(clamp(cfg_data, MAX_ROWS));
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= 2'd0;
        end
        else if (cmd.accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // row stores
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [3*PW-1:0]     ram_rdata;
    logic [1:0]          cslot_reg;
    logic [CW-1:0]       c_reg;
    logic [RW-1:0]       cr_reg;
    logic                int_reg;
    logic [AW-1:0]       cbase, abase;
    logic signed [PW-1:0] rd_pt [3];

    assign ram_waddr = base(slot_reg) + AW'(col_reg);
    assign cbase     = base(nxt3(nxt3(cslot_reg)));
    assign abase     = base(nxt3(cslot_reg));

    always_comb
    begin
        case (cmd.step[1:0])
            2'd0:    ram_raddr = cbase + AW'(c_reg);
            2'd1:    ram_raddr = cbase + AW'(c_reg) + AW'(1);
            2'd2:    ram_raddr = abase + AW'(c_reg);
            default: ram_raddr = cbase + AW'(c_reg) - AW'(1);
        endcase
    end

    assign rd_pt[0] = ram_rdata[3*PW-1:2*PW];
    assign rd_pt[1] = ram_rdata[2*PW-1:PW];
    assign rd_pt[2] = ram_rdata[PW-1:0];

    gpn_ram #(
        .WIDTH (3 * PW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (ram_waddr),
        .wdata ({point_x, point_y, point_z}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // arithmetic
    logic signed [PW-1:0]    p_reg [3];
    logic signed [PW-1:0]    o_reg [3];
    logic signed [DIFW-1:0]  a_reg [3];
    logic signed [DIFW-1:0]  b_reg [3];
    logic signed [DIFW-1:0]  d_reg [3];
    logic signed [DIFW-1:0]  e_reg [3];
    logic signed [NW-1:0]    n_reg [3];
    logic [NW-1:0]           mag_reg [3];
    logic signed [OPW-1:0]   opa, opb;
    logic signed [PRODW-1:0] prod_reg;
    logic [QW-1:0]           q_reg, srem_reg, root_reg, sbit_reg, sq_try;
    logic [REMW-1:0]         drem_reg, dsh_reg;
    logic [QUOW-1:0]         quo_reg, quo_next;
    logic                    dge;
    logic signed [NRMW-1:0]  res_reg [3];
    logic [NW-1:0]           mag_or;
    logic                    mag_hi;
    logic [1:0]              mcomp, mi1, mi2, acomp, sqi, dcomp;
    logic [3:0]              pstep;
    logic [LW-1:0]           len;

    assign mcomp  = idx3(cmd.step[3:2]);
    assign mi1    = nxt3(mcomp);
    assign mi2    = nxt3(mi1);
    assign pstep  = cmd.step[3:0] - 4'd1;
    assign acomp  = idx3(pstep[3:2]);
    assign sqi    = idx3(cmd.step[1:0]);
    assign dcomp  = idx3(cmd.step[5:4]);
    assign len    = root_reg[LW-1:0];
    assign mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign mag_hi = |mag_or[NW-1:30];
    assign sq_try = root_reg + sbit_reg;
    assign dge    = drem_reg >= dsh_reg;
    assign quo_next = {quo_reg[QUOW-2:0], dge};

    always_comb
    begin
        if (cmd.sq_en)
        begin
            opa = $signed({1'b0, mag_reg[sqi][OPW-2:0]});
            opb = $signed({1'b0, mag_reg[sqi][OPW-2:0]});
        end
        else
        begin
            case (cmd.step[1:0])
                2'd0:
                begin
                    opa = OPW'(a_reg[mi1]);
                    opb = OPW'(b_reg[mi2]);
                end
                2'd1:
                begin
                    opa = OPW'(a_reg[mi2]);
                    opb = OPW'(b_reg[mi1]);
                end
                2'd2:
                begin
                    opa = OPW'(d_reg[mi1]);
                    opb = OPW'(e_reg[mi2]);
                end
                default:
                begin
                    opa = OPW'(d_reg[mi2]);
                    opb = OPW'(e_reg[mi1]);
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;

        if (cmd.accept)
        begin
            p_reg[0]   <= point_x;
            p_reg[1]   <= point_y;
            p_reg[2]   <= point_z;
            cslot_reg  <= slot_reg;
            c_reg      <= col_reg;
            cr_reg     <= row_reg - 1'b1;
            int_reg    <= interior_now;
            res_reg[0] <= '0;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
        end

        if (cmd.rd_en && cmd.step != '0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                case (cmd.step[1:0])
                    2'd1:
                    begin
                        o_reg[i] <= rd_pt[i];
                        e_reg[i] <= DIFW'(p_reg[i]) - DIFW'(rd_pt[i]);
                    end
                    2'd2:    a_reg[i] <= DIFW'(rd_pt[i]) - DIFW'(o_reg[i]);
                    2'd3:    b_reg[i] <= DIFW'(rd_pt[i]) - DIFW'(o_reg[i]);
                    default: d_reg[i] <= DIFW'(rd_pt[i]) - DIFW'(o_reg[i]);
                endcase
            end
        end

        if (cmd.mul_en)
        begin
            if (cmd.step == '0)
            begin
                n_reg[0] <= '0;
                n_reg[1] <= '0;
                n_reg[2] <= '0;
            end
            else if (pstep[0])
                n_reg[acomp] <= n_reg[acomp] - NW'(prod_reg);
            else
                n_reg[acomp] <= n_reg[acomp] + NW'(prod_reg);
        end

        if (cmd.chk_en)
        begin
            for (int i = 0; i < 3; i++)
                mag_reg[i] <= n_reg[i][NW-1] ? NW'(-n_reg[i]) : NW'(n_reg[i]);
        end

        if (cmd.norm_en && !status.norm_ok)
        begin
            for (int i = 0; i < 3; i++)
                mag_reg[i] <= mag_hi ? (mag_reg[i] >> 1) : (mag_reg[i] << 1);
        end

        if (cmd.sq_en)
        begin
            if (cmd.step == '0)
                q_reg <= '0;
            else
                q_reg <= q_reg + QW'(prod_reg);
        end

        if (cmd.sqrt_en)
        begin
            if (cmd.step == '0)
            begin
                srem_reg <= q_reg;
                root_reg <= '0;
                sbit_reg <= SQRT_BIT0;
            end
            else
            begin
                if (srem_reg >= sq_try)
                begin
                    srem_reg <= srem_reg - sq_try;
                    root_reg <= (root_reg >> 1) + sbit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                sbit_reg <= sbit_reg >> 2;
            end
        end

        if (cmd.div_en)
        begin
            if (cmd.step[3:0] == 4'd0)
            begin
                drem_reg <= REMW'({mag_reg[dcomp][29:0], {QUOW{1'b0}}}) + REMW'(len);
                dsh_reg  <= REMW'({len, 1'b0}) << (QUOW - 1);
                quo_reg  <= '0;
            end
            else
            begin
                if (dge)
                    drem_reg <= drem_reg - dsh_reg;
                dsh_reg <= dsh_reg >> 1;
                quo_reg <= quo_next;
                if (cmd.step[3:0] == 4'd15)
                    res_reg[dcomp] <= n_reg[dcomp][NW-1] ? -NRMW'({1'b0, quo_next})
                                                        : NRMW'({1'b0, quo_next});
            end
        end
    end

    assign status.emit     = row_reg != '0;
    assign status.interior = interior_now;
    assign status.n_zero   = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
    assign status.norm_ok  = !mag_hi && mag_or[29];
    assign status.out_free = !out_valid || out_ready;

    // output register
    logic                   out_valid_reg;
    logic signed [NRMW-1:0] nx_reg, ny_reg, nz_reg;
    logic [POSW-1:0]        orow_reg, ocol_reg;
    logic                   oint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            nx_reg   <= res_reg[0];
            ny_reg   <= res_reg[1];
            nz_reg   <= res_reg[2];
            orow_reg <= POSW'(cr_reg);
            ocol_reg <= POSW'(c_reg);
            oint_reg <= int_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign center_row = orow_reg;
    assign center_col = ocol_reg;
    assign interior   = oint_reg;

endmodule

// ===== rtl/core/grid_point_normal_estimation_unit.sv =====
// Grid point normal estimation: top level.
//
// Points of an organized grid enter on the points channel in raster order,
// one signed Q11.12 point per word. Three rows are kept in one RAM. Each
// point of row r >= 1 yields one word on the normals channel: the unit
// normal (signed Q1.14) of the point at row r-1, same column. Row 0 yields
// nothing; the last row is never a center row.
// A row-0 point is only stored; a border center and a zero-length sum give a
// zero normal. Otherwise the shared 31x31 multiplier (12 cross terms,
// 3 squares), normalize shifts, a one-bit-per-cycle square root and a
// one-bit-per-cycle divider (three components) are used.
// A finished word waits in an output register; the next point is taken while
// it waits, and the sequencer holds only when a second result is ready before
// the first is taken. Writes on cfg (index 0: num_cols, index 1: num_rows) are
// clamped to [3, MAX] and restart the frame; cfg is always ready. The user must
// write cfg only while the block is idle; the block does not enforce this.
// Reset sets both sizes to 100 (MAX if smaller) and the frame to row 0.
module grid_point_normal_estimation_unit import gpn_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    gpn_point_if.sink      points,
    gpn_normal_if.source   normals,
    gpn_cfg_if.sink        cfg
);

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    gpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (points.valid),
        .in_ready (points.ready),
        .status   (status),
        .cmd      (cmd)
    );

    gpn_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .point_x    (points.point_x),
        .point_y    (points.point_y),
        .point_z    (points.point_z),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .out_valid  (normals.valid),
        .out_ready  (normals.ready),
        .normal_x   (normals.normal_x),
        .normal_y   (normals.normal_y),
        .normal_z   (normals.normal_z),
        .center_row (normals.center_row),
        .center_col (normals.center_col),
        .interior   (normals.interior)
    );

endmodule
